@@ hdl/i2a_pkg.sv @@
// shared constants, types and helpers for the integer to ascii formatter
`default_nettype none

package i2a_pkg;

    localparam int VALUE_W    = 64;
    localparam int DIGIT_W    = 4;
    localparam int DEC_DIGITS = 20;
    localparam int HEX_DIGITS = VALUE_W / DIGIT_W;
    localparam int DIG_REG_W  = DEC_DIGITS * DIGIT_W;
    localparam int NDIG_W     = $clog2(DEC_DIGITS + 1);
    localparam int FW_W       = 6;
    localparam int MAX_CHARS  = 32;
    localparam int CNT_W      = $clog2(VALUE_W);

    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_A     = 8'h61;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_MINUS = 8'h2d;

    typedef struct packed {
        logic start;
        logic hex_base;
        logic pop;
    } dgu_ctrl_t;

    typedef struct packed {
        logic                done;
        logic [NDIG_W-1:0]   ndig;
        logic [DIGIT_W-1:0]  top_digit;
    } dgu_stat_t;

    function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] c;
        if (d < DIGIT_W'(10))
            c = CHR_ZERO + {4'b0, d};
        else
            c = CHR_A + {4'b0, d} - 8'd10;
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hdl/i2a_digit_unit.sv @@
// digit engine: shift-add-3 binary to bcd, hex nibble load, leading zero strip, digit pop
`default_nettype none

module i2a_digit_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire i2a_pkg::dgu_ctrl_t            ctrl,
    input  wire logic [i2a_pkg::VALUE_W-1:0]   mag,
    output i2a_pkg::dgu_stat_t                 stat
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_CONV,
        D_NORM,
        D_DONE
    } dstate_t;

    dstate_t                          state_reg, state_next;
    logic [i2a_pkg::DIG_REG_W-1:0]    dig_reg, dig_next;
    logic [i2a_pkg::VALUE_W-1:0]      sh_reg, sh_next;
    logic [i2a_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic [i2a_pkg::NDIG_W-1:0]       ndig_reg, ndig_next;
    logic [i2a_pkg::DIG_REG_W-1:0]    corr;
    logic [i2a_pkg::DIGIT_W-1:0]      top;

    assign top = dig_reg[i2a_pkg::DIG_REG_W-1 -: i2a_pkg::DIGIT_W];

    // add 3 to every bcd digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++)
        begin
            if (dig_reg[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W] >= i2a_pkg::DIGIT_W'(5))
                corr[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W] =
                    dig_reg[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W] + i2a_pkg::DIGIT_W'(3);
            else
                corr[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W] =
                    dig_reg[i*i2a_pkg::DIGIT_W +: i2a_pkg::DIGIT_W];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        ndig_next  = ndig_reg;
        if (ctrl.start)
        begin
            cnt_next = '0;
            if (ctrl.hex_base)
            begin
                dig_next   = {mag, {(i2a_pkg::DIG_REG_W - i2a_pkg::VALUE_W){1'b0}}};
                ndig_next  = i2a_pkg::NDIG_W'(i2a_pkg::HEX_DIGITS);
                state_next = D_NORM;
            end
            else
            begin
                dig_next   = '0;
                sh_next    = mag;
                ndig_next  = i2a_pkg::NDIG_W'(i2a_pkg::DEC_DIGITS);
                state_next = D_CONV;
            end
        end
        else
        begin
            unique case (state_reg)
                D_IDLE:
                begin
                end
                D_CONV:
                begin
                    dig_next = {corr[i2a_pkg::DIG_REG_W-2:0], sh_reg[i2a_pkg::VALUE_W-1]};
                    sh_next  = {sh_reg[i2a_pkg::VALUE_W-2:0], 1'b0};
                    cnt_next = cnt_reg + i2a_pkg::CNT_W'(1);
                    if (cnt_reg == i2a_pkg::CNT_W'(i2a_pkg::VALUE_W - 1))
                        state_next = D_NORM;
                end
                D_NORM:
                begin
                    // strip leading zeros, keep at least one digit
                    if (ndig_reg > i2a_pkg::NDIG_W'(1) && top == '0)
                    begin
                        dig_next  = {dig_reg[i2a_pkg::DIG_REG_W-i2a_pkg::DIGIT_W-1:0],
                                     {i2a_pkg::DIGIT_W{1'b0}}};
                        ndig_next = ndig_reg - i2a_pkg::NDIG_W'(1);
                    end
                    else
                        state_next = D_DONE;
                end
                D_DONE:
                begin
                    if (ctrl.pop)
                    begin
                        dig_next  = {dig_reg[i2a_pkg::DIG_REG_W-i2a_pkg::DIGIT_W-1:0],
                                     {i2a_pkg::DIGIT_W{1'b0}}};
                        ndig_next = ndig_reg - i2a_pkg::NDIG_W'(1);
                    end
                end
                default:
                begin
                    state_next = D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            ndig_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ndig_reg  <= ndig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
        sh_reg  <= sh_next;
    end

    assign stat.done      = (state_reg == D_DONE);
    assign stat.ndig      = ndig_reg;
    assign stat.top_digit = top;

endmodule

`default_nettype wire

@@ hdl/integer_to_ascii_padded.sv @@
// top level: formats a 64-bit integer as padded decimal or hex ascii, one character per transfer
//
//  channel | direction | handshake              | payload
//  num     | in        | num_valid / num_ready  | value_bits, is_signed, hex_base,
//          |           |                        | field_width, zero_pad
//  chr     | out       | chr_valid / chr_ready  | out_char, last_char
//
// one number at a time: num_ready is high only while idle
// decimal runs shift-add-3 over all 64 input bits, then strips leading zeros (up to 19)
// hex skips the conversion and goes straight to the zero strip (up to 15 zeros)
// then one character per cycle while chr_ready is high, up to 32 characters
// a stall on chr holds the character register and the sequencer; reset idles everything
`default_nettype none

module integer_to_ascii_padded (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          num_valid,
    output logic                               num_ready,
    input  wire logic [i2a_pkg::VALUE_W-1:0]   value_bits,
    input  wire logic                          is_signed,
    input  wire logic                          hex_base,
    input  wire logic [i2a_pkg::FW_W-1:0]      field_width,
    input  wire logic                          zero_pad,
    output logic                               chr_valid,
    input  wire logic                          chr_ready,
    output logic [7:0]                         out_char,
    output logic                               last_char
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT,
        S_SPAD,
        S_SIGN,
        S_ZPAD,
        S_DIGIT
    } state_t;

    state_t                        state_reg, state_next;
    logic                          neg_reg, neg_next;
    logic                          zpad_reg, zpad_next;
    logic [i2a_pkg::FW_W-1:0]      width_reg, width_next;
    logic [i2a_pkg::FW_W-1:0]      pad_cnt_reg, pad_cnt_next;
    logic                          chr_valid_reg, chr_valid_next;
    logic [7:0]                    out_char_reg, out_char_next;
    logic                          last_reg, last_next;

    logic                          accept;
    logic                          neg_in;
    logic [i2a_pkg::VALUE_W-1:0]   mag;
    logic                          can_load;
    logic [i2a_pkg::FW_W-1:0]      len;
    logic [i2a_pkg::FW_W-1:0]      pads;
    i2a_pkg::dgu_ctrl_t            dctrl;
    i2a_pkg::dgu_stat_t            dstat;

    assign num_ready = (state_reg == S_IDLE);
    assign accept    = num_valid && num_ready;
    assign neg_in    = is_signed && value_bits[i2a_pkg::VALUE_W-1];
    assign mag       = neg_in ? (~value_bits + i2a_pkg::VALUE_W'(1)) : value_bits;
    assign can_load  = !chr_valid_reg || chr_ready;

    assign len  = i2a_pkg::FW_W'(dstat.ndig) + i2a_pkg::FW_W'(neg_reg);
    assign pads = (width_reg > len) ? (width_reg - len) : '0;

    assign dctrl.start    = accept;
    assign dctrl.hex_base = hex_base;
    assign dctrl.pop      = (state_reg == S_DIGIT) && can_load;

    i2a_digit_unit u_digits (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (dctrl),
        .mag   (mag),
        .stat  (dstat)
    );

    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        zpad_next      = zpad_reg;
        width_next     = width_reg;
        pad_cnt_next   = pad_cnt_reg;
        chr_valid_next = chr_valid_reg && !chr_ready;
        out_char_next  = out_char_reg;
        last_next      = last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = neg_in;
                    zpad_next  = zero_pad;
                    width_next = (field_width > i2a_pkg::FW_W'(i2a_pkg::MAX_CHARS)) ?
                                 i2a_pkg::FW_W'(i2a_pkg::MAX_CHARS) : field_width;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (dstat.done)
                begin
                    pad_cnt_next = pads;
                    if (pads != '0 && !zpad_reg)
                        state_next = S_SPAD;
                    else if (neg_reg)
                        state_next = S_SIGN;
                    else if (pads != '0)
                        state_next = S_ZPAD;
                    else
                        state_next = S_DIGIT;
                end
            end
            S_SPAD:
            begin
                if (can_load)
                begin
                    chr_valid_next = 1'b1;
                    out_char_next  = i2a_pkg::CHR_SPACE;
                    last_next      = 1'b0;
                    pad_cnt_next   = pad_cnt_reg - i2a_pkg::FW_W'(1);
                    if (pad_cnt_reg == i2a_pkg::FW_W'(1))
                        state_next = neg_reg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN:
            begin
                if (can_load)
                begin
                    chr_valid_next = 1'b1;
                    out_char_next  = i2a_pkg::CHR_MINUS;
                    last_next      = 1'b0;
                    // sign goes ahead of zero padding
                    state_next     = (zpad_reg && pad_cnt_reg != '0) ? S_ZPAD : S_DIGIT;
                end
            end
            S_ZPAD:
            begin
                if (can_load)
                begin
                    chr_valid_next = 1'b1;
                    out_char_next  = i2a_pkg::CHR_ZERO;
                    last_next      = 1'b0;
                    pad_cnt_next   = pad_cnt_reg - i2a_pkg::FW_W'(1);
                    if (pad_cnt_reg == i2a_pkg::FW_W'(1))
                        state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (can_load)
                begin
                    chr_valid_next = 1'b1;
                    out_char_next  = i2a_pkg::digit_char(dstat.top_digit);
                    last_next      = (dstat.ndig == i2a_pkg::NDIG_W'(1));
                    if (dstat.ndig == i2a_pkg::NDIG_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            neg_reg       <= 1'b0;
            zpad_reg      <= 1'b0;
            width_reg     <= '0;
            pad_cnt_reg   <= '0;
            chr_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            zpad_reg      <= zpad_next;
            width_reg     <= width_next;
            pad_cnt_reg   <= pad_cnt_next;
            chr_valid_reg <= chr_valid_next;
            out_char_reg  <= out_char_next;
            last_reg      <= last_next;
        end
    end

    assign chr_valid = chr_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_reg;

endmodule

`default_nettype wire
